[src/ogcu_pkg.sv]
`default_nettype none

package ogcu_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
   localparam logic [2:0] REG_CELLS_PER_MM = 3'd2;
   localparam logic [2:0] REG_GRID_WIDTH   = 3'd3;
   localparam logic [2:0] REG_GRID_HEIGHT  = 3'd4;
   localparam logic [2:0] REG_RAISE_STEP   = 3'd5;
   localparam logic [2:0] REG_LOWER_STEP   = 3'd6;

   // result status codes
   localparam logic [1:0] STATUS_UPDATED = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   localparam int POS_W    = 24;
   localparam int SCALE_W  = 16;
   localparam int GRID_W   = 9;
   localparam int STEP_W   = 11;
   localparam int CONF_W   = 11;
   localparam int OCC_W    = 7;
   localparam int IDX_W    = 16;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // grid dimensions up to 4096 and 9-bit size registers both fit here
   localparam int DIM_W = 13;

   localparam logic [CONF_W-1:0] CONF_FULL = 11'd1024;
   localparam logic [OCC_W-1:0]  OCC_SCALE = 7'd100;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [POS_W-1:0]   origin_x;
      logic [POS_W-1:0]   origin_y;
      logic [SCALE_W-1:0] cells_per_mm;
      logic [GRID_W-1:0]  grid_width;
      logic [GRID_W-1:0]  grid_height;
      logic [STEP_W-1:0]  raise_step;
      logic [STEP_W-1:0]  lower_step;
   } cfg_type;

endpackage

`default_nettype wire

[src/occupancy_grid_cell_update.sv]
// path: an accepted req_ word passes the three front stages, a queue slot and the
//   registered read of the confidence ram, then the write and the result register
// flow: the back end takes a new word only after the read-modify-write of the
//   confidence ram (registered read, then write) for the last one is done
// reset: synchronous, active high; afterwards a clearing pass zeroes all
//   MAX_COLS*MAX_ROWS confidence cells, one per cycle, with req_ready held low
`default_nettype none

module occupancy_grid_cell_update #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input points
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [ogcu_pkg::POS_W-1:0]    req_point_x,
   input  wire logic signed [ogcu_pkg::POS_W-1:0]    req_point_y,
   input  wire logic                                 req_point_valid,
   input  wire logic                                 req_lane_hit,
   // results
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [ogcu_pkg::IDX_W-1:0]           rsp_cell_index,
   output logic      [ogcu_pkg::OCC_W-1:0]           rsp_occupancy,
   output logic      [ogcu_pkg::STATUS_W-1:0]        rsp_status,
   // register writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ogcu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ogcu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // size of the confidence store and its address width
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   // queue word: cell index, status, lane hit
   localparam int QW    = AW + ogcu_pkg::STATUS_W + 1;

   ogcu_pkg::cfg_type cfg;

   logic          clear_busy;
   logic          front_in_valid, front_in_ready;
   logic          f_valid, f_ready;
   logic [AW-1:0] f_idx;
   logic [1:0]    f_status;
   logic          f_hit;
   logic          q_valid, q_ready;
   logic [QW-1:0] q_push_data, q_pop_data;

   // configuration registers
   ogcu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // no points taken while the store is being cleared
   assign front_in_valid = req_valid && !clear_busy;
   assign req_ready      = front_in_ready && !clear_busy;

   // front end: origin offset, scaling, bounds check, row-major index
   ogcu_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .AW       (AW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (front_in_valid),
      .in_ready    (front_in_ready),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .point_valid (req_point_valid),
      .lane_hit    (req_lane_hit),
      .out_valid   (f_valid),
      .out_ready   (f_ready),
      .out_idx     (f_idx),
      .out_status  (f_status),
      .out_hit     (f_hit)
   );

   assign q_push_data = {f_idx, f_status, f_hit};

   // decoupling queue between classification and cell update
   ogcu_queue #(
      .WIDTH (QW),
      .DEPTH (ogcu_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_pop_data)
   );

   // back end: confidence read-modify-write and result register
   ogcu_back #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .clear_busy     (clear_busy),
      .in_valid       (q_valid),
      .in_ready       (q_ready),
      .in_idx         (q_pop_data[QW-1 -: AW]),
      .in_status      (q_pop_data[ogcu_pkg::STATUS_W:1]),
      .in_hit         (q_pop_data[0]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_index (rsp_cell_index),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_status     (rsp_status)
   );

`ifndef SYNTHESIS
   // nothing enters while the clearing pass runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("point accepted during clearing pass");

   // skipped and dropped points carry zero index and occupancy
   a_skip_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ogcu_pkg::STATUS_UPDATED)
         |-> (rsp_cell_index == '0 && rsp_occupancy == '0))
      else $error("nonzero fields on a skipped point");

   // confidence saturates at full scale so occupancy stays a percent
   a_occupancy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= ogcu_pkg::OCC_SCALE))
      else $error("occupancy above 100");

   // the queue is not popped while the store is still being cleared
   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !q_ready)
      else $error("queue popped during clearing pass");
`endif

endmodule

`default_nettype wire

[src/ogcu_ram.sv]
`default_nettype none

module ogcu_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[src/ogcu_queue.sv]
`default_nettype none

module ogcu_queue #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/ogcu_csr.sv]
`default_nettype none

module ogcu_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ogcu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ogcu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output ogcu_pkg::cfg_type                     cfg
);

   ogcu_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ogcu_pkg::REG_ORIGIN_X:     cfg_in.origin_x     = csr_wdata;
            ogcu_pkg::REG_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata;
            ogcu_pkg::REG_CELLS_PER_MM: cfg_in.cells_per_mm = csr_wdata[15:0];
            ogcu_pkg::REG_GRID_WIDTH:   cfg_in.grid_width   = csr_wdata[8:0];
            ogcu_pkg::REG_GRID_HEIGHT:  cfg_in.grid_height  = csr_wdata[8:0];
            ogcu_pkg::REG_RAISE_STEP:   cfg_in.raise_step   = csr_wdata[10:0];
            ogcu_pkg::REG_LOWER_STEP:   cfg_in.lower_step   = csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x     <= 24'd0;
         cfg_ff.origin_y     <= 24'd0;
         cfg_ff.cells_per_mm <= 16'd1311;
         cfg_ff.grid_width   <= 9'd256;
         cfg_ff.grid_height  <= 9'd256;
         cfg_ff.raise_step   <= 11'd102;
         cfg_ff.lower_step   <= 11'd51;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[src/ogcu_front.sv]
`default_nettype none

module ogcu_front #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256,
   parameter int AW       = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  ogcu_pkg::cfg_type                         cfg,
   input  wire logic                                 in_valid,
   output logic                                      in_ready,
   input  wire logic signed [ogcu_pkg::POS_W-1:0]    point_x,
   input  wire logic signed [ogcu_pkg::POS_W-1:0]    point_y,
   input  wire logic                                 point_valid,
   input  wire logic                                 lane_hit,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output logic      [AW-1:0]                        out_idx,
   output logic      [ogcu_pkg::STATUS_W-1:0]        out_status,
   output logic                                      out_hit
);

   localparam int PW  = ogcu_pkg::POS_W;
   localparam int DW  = ogcu_pkg::DIM_W;
   localparam int MW  = ogcu_pkg::POS_W + ogcu_pkg::SCALE_W;
   localparam int IW  = 2 * ogcu_pkg::DIM_W;
   localparam logic [DW-1:0] COLS_LIM = DW'(MAX_COLS);
   localparam logic [DW-1:0] ROWS_LIM = DW'(MAX_ROWS);

   // stage 1: offsets from origin
   logic          v1_ff, v1_in;
   logic [PW:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic          ok1_ff, hit1_ff;
   // stage 2: cell coordinates
   logic          v2_ff, v2_in;
   logic [PW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic          neg2_ff, ok2_ff, hit2_ff;
   // stage 3: bounds and row-major index
   logic          v3_ff, v3_in;
   logic [AW-1:0] idx3_ff, idx3_in;
   logic [1:0]    st3_ff, st3_in;
   logic          hit3_ff;

   logic          en1, en2, en3;
   logic [MW-1:0] prod_x, prod_y;
   logic [DW-1:0] gw_ext, gh_ext, gw_eff, gh_eff;
   logic          on_grid;
   logic [IW-1:0] idx_sum;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign out_valid  = v3_ff;
   assign out_idx    = idx3_ff;
   assign out_status = st3_ff;
   assign out_hit    = hit3_ff;

   // sign-extended subtract, bit PW is the sign of the offset
   assign dx_in = {point_x[PW-1], point_x} - {cfg.origin_x[PW-1], cfg.origin_x};
   assign dy_in = {point_y[PW-1], point_y} - {cfg.origin_y[PW-1], cfg.origin_y};
   assign v1_in = en1 ? in_valid : v1_ff;

   // scale by cells per mm, 16 fraction bits dropped
   assign prod_x = MW'(dx_ff[PW-1:0]) * MW'(cfg.cells_per_mm);
   assign prod_y = MW'(dy_ff[PW-1:0]) * MW'(cfg.cells_per_mm);
   assign cx_in  = prod_x[MW-1:ogcu_pkg::SCALE_W];
   assign cy_in  = prod_y[MW-1:ogcu_pkg::SCALE_W];
   assign v2_in  = en2 ? v1_ff : v2_ff;

   // grid size clipped to the store dimensions
   assign gw_ext  = DW'(cfg.grid_width);
   assign gh_ext  = DW'(cfg.grid_height);
   assign gw_eff  = (gw_ext > COLS_LIM) ? COLS_LIM : gw_ext;
   assign gh_eff  = (gh_ext > ROWS_LIM) ? ROWS_LIM : gh_ext;
   assign on_grid = !neg2_ff && (cx_ff < PW'(gw_eff)) && (cy_ff < PW'(gh_eff));
   assign idx_sum = IW'(cy_ff[DW-1:0]) * IW'(gw_eff) + IW'(cx_ff[DW-1:0]);
   assign v3_in   = en3 ? v2_ff : v3_ff;

   always_comb begin
      if (!ok2_ff) begin
         st3_in  = ogcu_pkg::STATUS_INVALID;
         idx3_in = '0;
      end else if (!on_grid) begin
         st3_in  = ogcu_pkg::STATUS_OUTSIDE;
         idx3_in = '0;
      end else begin
         st3_in  = ogcu_pkg::STATUS_UPDATED;
         idx3_in = idx_sum[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (en1) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         ok1_ff  <= point_valid;
         hit1_ff <= lane_hit;
      end
      if (en2) begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         neg2_ff <= dx_ff[PW] || dy_ff[PW];
         ok2_ff  <= ok1_ff;
         hit2_ff <= hit1_ff;
      end
      if (en3) begin
         idx3_ff <= idx3_in;
         st3_ff  <= st3_in;
         hit3_ff <= hit2_ff;
      end
   end

endmodule

`default_nettype wire

[src/ogcu_back.sv]
`default_nettype none

module ogcu_back #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  ogcu_pkg::cfg_type                     cfg,
   output logic                                  clear_busy,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic [AW-1:0]                    in_idx,
   input  wire logic [ogcu_pkg::STATUS_W-1:0]    in_status,
   input  wire logic                             in_hit,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [ogcu_pkg::IDX_W-1:0]       rsp_cell_index,
   output logic      [ogcu_pkg::OCC_W-1:0]       rsp_occupancy,
   output logic      [ogcu_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int CW = ogcu_pkg::CONF_W;
   localparam int OW = ogcu_pkg::OCC_W;
   localparam int PW = ogcu_pkg::CONF_W + ogcu_pkg::OCC_W;

   // clearing pass
   logic          clear_ff, clear_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   // item whose cell read is in flight
   logic          busy_ff, busy_in;
   logic [AW-1:0] b_idx_ff;
   logic [1:0]    b_status_ff;
   logic          b_hit_ff;
   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ogcu_pkg::IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [OW-1:0] rsp_occ_ff, rsp_occ_in;
   logic [1:0]    rsp_status_ff;

   logic          pop;
   logic [CW-1:0] conf_rd, conf_new;
   logic [CW:0]   conf_sum;
   logic [PW-1:0] occ_prod;
   logic          updating;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] wr_data;
   logic [31:0]   idx_wide;

   ogcu_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_conf_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (in_idx),
      .rd_data (conf_rd)
   );

   // one cell read-modify-write at a time, result slot must be free by the write cycle
   assign pop      = !clear_ff && !busy_ff && in_valid && (!rsp_valid_ff || rsp_ready);
   assign in_ready = pop;
   assign busy_in  = pop;
   assign updating = busy_ff && (b_status_ff == ogcu_pkg::STATUS_UPDATED);

   always_comb begin
      conf_sum = {1'b0, conf_rd} + {1'b0, cfg.raise_step};
      if (b_hit_ff) begin
         conf_new = (conf_sum > (CW + 1)'(ogcu_pkg::CONF_FULL)) ? ogcu_pkg::CONF_FULL
                                                               : conf_sum[CW-1:0];
      end else begin
         conf_new = (conf_rd > cfg.lower_step) ? conf_rd - cfg.lower_step : '0;
      end
   end

   // percent = conf * 100 / 1024
   assign occ_prod = PW'(conf_new) * PW'(ogcu_pkg::OCC_SCALE);
   assign idx_wide = 32'(b_idx_ff);

   always_comb begin
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = updating;
         wr_addr = b_idx_ff;
         wr_data = conf_new;
      end
   end

   assign clear_in    = clear_ff && (clr_addr_ff != AW'(DEPTH - 1));
   assign clr_addr_in = clr_addr_ff + 1'b1;
   assign clear_busy  = clear_ff;

   always_comb begin
      rsp_valid_in = busy_ff || (rsp_valid_ff && !rsp_ready);
      rsp_idx_in   = updating ? idx_wide[ogcu_pkg::IDX_W-1:0] : '0;
      rsp_occ_in   = updating ? occ_prod[PW-1-(PW-10-OW):10] : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_idx_ff;
   assign rsp_occupancy  = rsp_occ_ff;
   assign rsp_status     = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         b_idx_ff    <= in_idx;
         b_status_ff <= in_status;
         b_hit_ff    <= in_hit;
      end
      if (busy_ff) begin
         rsp_idx_ff    <= rsp_idx_in;
         rsp_occ_ff    <= rsp_occ_in;
         rsp_status_ff <= b_status_ff;
      end
   end

endmodule

`default_nettype wire

[sim/occupancy_grid_cell_update_test.sv]
`default_nettype none

module occupancy_grid_cell_update_test;

   localparam int GRID_COLS    = 256;
   localparam int GRID_ROWS    = 256;
   // cycles with no handshake at all before the run is declared hung;
   // covers the post-reset clearing pass of every cell several times over
   localparam int HANG_LIMIT   = 300000;
   // quiet cycles after the last result of a phase
   localparam int SETTLE_WAIT  = 12;
   localparam int PHASES       = 12;
   localparam int POINTS_EACH  = 158;
   // csr index that maps to no register
   localparam logic [ogcu_pkg::CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [ogcu_pkg::IDX_W-1:0]    cell_index;
      logic [ogcu_pkg::OCC_W-1:0]    occupancy;
      logic [ogcu_pkg::STATUS_W-1:0] status;
   } cell_word_type;

   typedef struct {
      logic [ogcu_pkg::POS_W-1:0]   origin_x;
      logic [ogcu_pkg::POS_W-1:0]   origin_y;
      logic [ogcu_pkg::SCALE_W-1:0] cells_per_mm;
      logic [ogcu_pkg::GRID_W-1:0]  grid_width;
      logic [ogcu_pkg::GRID_W-1:0]  grid_height;
      logic [ogcu_pkg::STEP_W-1:0]  raise_step;
      logic [ogcu_pkg::STEP_W-1:0]  lower_step;
   } map_setting_type;

   // mirror of the map registers and the confidence store; predicts each result word
   class cell_confidence_model;
      logic [ogcu_pkg::POS_W-1:0]   origin_x, origin_y;
      logic [ogcu_pkg::SCALE_W-1:0] cells_per_mm;
      logic [ogcu_pkg::GRID_W-1:0]  grid_width, grid_height;
      logic [ogcu_pkg::STEP_W-1:0]  raise_step, lower_step;
      logic [ogcu_pkg::CONF_W-1:0]  confidence [GRID_COLS*GRID_ROWS];
      cell_word_type                expected_cells [$];
      int mismatches, updated, skipped, off_grid, at_full, checked;

      function new();
         origin_x     = '0;
         origin_y     = '0;
         cells_per_mm = 16'd1311;
         grid_width   = 9'd256;
         grid_height  = 9'd256;
         raise_step   = 11'd102;
         lower_step   = 11'd51;
         foreach (confidence[i]) confidence[i] = '0;
         mismatches = 0;
         updated    = 0;
         skipped    = 0;
         off_grid   = 0;
         at_full    = 0;
         checked    = 0;
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      function void set_register(logic [ogcu_pkg::CSR_IDX_W-1:0] index,
                                 logic [ogcu_pkg::CSR_DATA_W-1:0] data);
         case (index)
            ogcu_pkg::REG_ORIGIN_X:     origin_x     = data[ogcu_pkg::POS_W-1:0];
            ogcu_pkg::REG_ORIGIN_Y:     origin_y     = data[ogcu_pkg::POS_W-1:0];
            ogcu_pkg::REG_CELLS_PER_MM: cells_per_mm = data[ogcu_pkg::SCALE_W-1:0];
            ogcu_pkg::REG_GRID_WIDTH:   grid_width   = data[ogcu_pkg::GRID_W-1:0];
            ogcu_pkg::REG_GRID_HEIGHT:  grid_height  = data[ogcu_pkg::GRID_W-1:0];
            ogcu_pkg::REG_RAISE_STEP:   raise_step   = data[ogcu_pkg::STEP_W-1:0];
            ogcu_pkg::REG_LOWER_STEP:   lower_step   = data[ogcu_pkg::STEP_W-1:0];
            default: ;
         endcase
      endfunction

      // cell coordinate on one axis; false when the point lies below the origin
      function bit axis_cell(logic [ogcu_pkg::POS_W-1:0] pos, logic [ogcu_pkg::POS_W-1:0] org,
                             output longint coord);
         longint offset, scale;
         offset = $signed(pos);
         offset = offset - $signed(org);
         scale  = cells_per_mm;
         coord  = (offset * scale) >>> 16;
         return offset >= 0;
      endfunction

      function void predict_cell_update(logic [ogcu_pkg::POS_W-1:0] x,
                                        logic [ogcu_pkg::POS_W-1:0] y,
                                        logic point_valid, logic lane_hit);
         cell_word_type word;
         longint        cx, cy;
         bit            in_x, in_y;
         int            cols, rows, idx, conf;
         word = '0;
         cols = grid_width > GRID_COLS ? GRID_COLS : grid_width;
         rows = grid_height > GRID_ROWS ? GRID_ROWS : grid_height;
         if (!point_valid) begin
            word.status = ogcu_pkg::STATUS_INVALID;
            skipped++;
         end else begin
            in_x = axis_cell(x, origin_x, cx);
            in_y = axis_cell(y, origin_y, cy);
            if (!in_x || !in_y || cx >= cols || cy >= rows) begin
               word.status = ogcu_pkg::STATUS_OUTSIDE;
               off_grid++;
            end else begin
               idx  = int'(cx + cy * cols);
               conf = confidence[idx];
               if (lane_hit)
                  conf = (conf + raise_step > ogcu_pkg::CONF_FULL) ? ogcu_pkg::CONF_FULL
                                                                   : conf + raise_step;
               else
                  conf = (conf > lower_step) ? conf - lower_step : 0;
               confidence[idx] = conf[ogcu_pkg::CONF_W-1:0];
               word.cell_index = idx[ogcu_pkg::IDX_W-1:0];
               word.occupancy  = ogcu_pkg::OCC_W'((conf * ogcu_pkg::OCC_SCALE) >> 10);
               word.status     = ogcu_pkg::STATUS_UPDATED;
               updated++;
               if (conf == ogcu_pkg::CONF_FULL) at_full++;
            end
         end
         expected_cells.insert(expected_cells.size(), word);
      endfunction

      task check_cell_result(logic [ogcu_pkg::IDX_W-1:0] cell_index,
                             logic [ogcu_pkg::OCC_W-1:0] occupancy,
                             logic [ogcu_pkg::STATUS_W-1:0] status);
         cell_word_type want;
         if (expected_cells.size() == 0) begin
            report($sformatf("result (cell %0d, occ %0d, status %0d) with none pending",
                             cell_index, occupancy, status));
            return;
         end
         want = expected_cells.pop_front();
         checked++;
         if (cell_index !== want.cell_index)
            report($sformatf("result %0d: cell index %0d, expected %0d",
                             checked, cell_index, want.cell_index));
         if (occupancy !== want.occupancy)
            report($sformatf("result %0d: occupancy %0d, expected %0d",
                             checked, occupancy, want.occupancy));
         if (status !== want.status)
            report($sformatf("result %0d: status %0d, expected %0d",
                             checked, status, want.status));
      endtask
   endclass

   // clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid       = 1'b0;
   logic                              req_ready;
   logic [ogcu_pkg::POS_W-1:0]        req_point_x     = '0;
   logic [ogcu_pkg::POS_W-1:0]        req_point_y     = '0;
   logic                              req_point_valid = 1'b0;
   logic                              req_lane_hit    = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready       = 1'b0;
   logic [ogcu_pkg::IDX_W-1:0]        rsp_cell_index;
   logic [ogcu_pkg::OCC_W-1:0]        rsp_occupancy;
   logic [ogcu_pkg::STATUS_W-1:0]     rsp_status;
   logic                              csr_valid       = 1'b0;
   logic                              csr_ready;
   logic [ogcu_pkg::CSR_IDX_W-1:0]    csr_index       = '0;
   logic [ogcu_pkg::CSR_DATA_W-1:0]   csr_wdata       = '0;

   cell_confidence_model board;
   map_setting_type      current_map;
   bit                   calm = 1'b0;     // no idling on either side while set
   int                   hit_pct = 50;    // lane-hit share of well-formed points
   int                   quiet_cycles = 0;
   int                   settings_applied = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   occupancy_grid_cell_update #(
      .MAX_COLS(GRID_COLS),
      .MAX_ROWS(GRID_ROWS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_valid (req_point_valid),
      .req_lane_hit    (req_lane_hit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // idle cycles before the next word on either side
   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   // monitor: every handshake is seen here with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.set_register(csr_index, csr_wdata);
         if (req_valid && req_ready)
            board.predict_cell_update(req_point_x, req_point_y, req_point_valid, req_lane_hit);
         if (rsp_valid && rsp_ready)
            board.check_cell_result(rsp_cell_index, rsp_occupancy, rsp_status);
         // watchdog, also spans the clearing pass after reset
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     quiet_cycles, board.expected_cells.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // result side back-pressure: random stall before each word
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // one register write; returns at the accepting edge with csr_valid still high
   task automatic write_reg(logic [ogcu_pkg::CSR_IDX_W-1:0] index,
                            logic [ogcu_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // one point word; returns at the accepting edge with req_valid still high
   task automatic send_point(logic [ogcu_pkg::POS_W-1:0] x, logic [ogcu_pkg::POS_W-1:0] y,
                             logic pv, logic hit);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_point_x     <= x;
      req_point_y     <= y;
      req_point_valid <= pv;
      req_lane_hit    <= hit;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending, wait for every pending result, then SETTLE_WAIT quiet cycles
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   function automatic map_setting_type make_setting(logic [ogcu_pkg::POS_W-1:0] ox,
                                                    logic [ogcu_pkg::POS_W-1:0] oy,
                                                    logic [ogcu_pkg::SCALE_W-1:0] cpm,
                                                    logic [ogcu_pkg::GRID_W-1:0] gw,
                                                    logic [ogcu_pkg::GRID_W-1:0] gh,
                                                    logic [ogcu_pkg::STEP_W-1:0] raise,
                                                    logic [ogcu_pkg::STEP_W-1:0] lower);
      map_setting_type s;
      s.origin_x     = ox;
      s.origin_y     = oy;
      s.cells_per_mm = cpm;
      s.grid_width   = gw;
      s.grid_height  = gh;
      s.raise_step   = raise;
      s.lower_step   = lower;
      return s;
   endfunction

   // writes every register; junk above each register's width must be dropped
   task automatic apply_setting(map_setting_type s);
      write_reg(ogcu_pkg::REG_ORIGIN_X, s.origin_x);
      write_reg(ogcu_pkg::REG_ORIGIN_Y, s.origin_y);
      write_reg(ogcu_pkg::REG_CELLS_PER_MM, {8'($urandom), s.cells_per_mm});
      write_reg(ogcu_pkg::REG_GRID_WIDTH, {15'($urandom), s.grid_width});
      write_reg(ogcu_pkg::REG_GRID_HEIGHT, {15'($urandom), s.grid_height});
      write_reg(ogcu_pkg::REG_RAISE_STEP, {13'($urandom), s.raise_step});
      write_reg(ogcu_pkg::REG_LOWER_STEP, {13'($urandom), s.lower_step});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, 24'($urandom));
      csr_valid <= 1'b0;
      current_map = s;
      settings_applied++;
   endtask

   function automatic logic [ogcu_pkg::GRID_W-1:0] random_dim();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ogcu_pkg::GRID_W'($urandom_range(257, 511));
         2: return 9'd256;
         3: return ogcu_pkg::GRID_W'($urandom_range(1, 256));
         default: return ogcu_pkg::GRID_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [ogcu_pkg::STEP_W-1:0] random_step();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ogcu_pkg::CONF_FULL;
         2: return ogcu_pkg::STEP_W'($urandom_range(1025, 2047));
         default: return ogcu_pkg::STEP_W'($urandom_range(1, 300));
      endcase
   endfunction

   function automatic logic [ogcu_pkg::POS_W-1:0] random_origin();
      case ($urandom_range(0, 5))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         default: return ogcu_pkg::POS_W'($urandom_range(0, 2000000) - 1000000);
      endcase
   endfunction

   function automatic map_setting_type random_setting();
      logic [ogcu_pkg::SCALE_W-1:0] cpm;
      case ($urandom_range(0, 7))
         0: cpm = '0;
         1: cpm = 16'd1;
         2: cpm = 16'hFFFF;
         3: cpm = ogcu_pkg::SCALE_W'($urandom_range(2, 200));
         default: cpm = ogcu_pkg::SCALE_W'($urandom_range(200, 65535));
      endcase
      return make_setting(random_origin(), random_origin(), cpm, random_dim(), random_dim(),
                          random_step(), random_step());
   endfunction

   // millimetres spanned by one more cell than the grid holds, so points land
   // mostly on the grid with some just past its far edge
   function automatic int cell_reach(int count, logic [ogcu_pkg::SCALE_W-1:0] cpm);
      longint reach;
      if (cpm == 0) return 4000;
      reach = (longint'(count + 1) * 65536) / cpm;
      return reach > 24'hFFFFFF ? 24'hFFFFFF : int'(reach);
   endfunction

   // mostly well-formed points aimed at the grid, the rest invalid, below the
   // origin, or fully random
   task automatic random_point(map_setting_type s);
      int                         cols, rows, kind;
      logic [ogcu_pkg::POS_W-1:0] x, y;
      logic                       pv, hit;
      cols = s.grid_width > GRID_COLS ? GRID_COLS : s.grid_width;
      rows = s.grid_height > GRID_ROWS ? GRID_ROWS : s.grid_height;
      kind = $urandom_range(0, 99);
      pv   = 1'b1;
      hit  = $urandom_range(0, 99) < hit_pct;
      x    = s.origin_x
             + ogcu_pkg::POS_W'($urandom_range(0, cell_reach(cols, s.cells_per_mm)));
      y    = s.origin_y
             + ogcu_pkg::POS_W'($urandom_range(0, cell_reach(rows, s.cells_per_mm)));
      if (kind >= 94) begin
         x   = ogcu_pkg::POS_W'($urandom);
         y   = ogcu_pkg::POS_W'($urandom);
         pv  = 1'($urandom_range(0, 1));
         hit = 1'($urandom_range(0, 1));
      end else if (kind >= 88) begin
         pv = 1'b0;
      end else if (kind >= 80) begin
         case ($urandom_range(0, 2))
            0: x = s.origin_x - ogcu_pkg::POS_W'($urandom_range(1, 2000));
            1: y = s.origin_y - ogcu_pkg::POS_W'($urandom_range(1, 2000));
            default: begin
               x = s.origin_x - ogcu_pkg::POS_W'($urandom_range(1, 2000));
               y = s.origin_y - ogcu_pkg::POS_W'($urandom_range(1, 2000));
            end
         endcase
      end
      send_point(x, y, pv, hit);
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // unmapped index first: the reset values must still hold after it
      write_reg(REG_UNMAPPED, 24'hFFFFFF);
      csr_valid <= 1'b0;
      current_map = make_setting('0, '0, 16'd1311, 9'd256, 9'd256, 11'd102, 11'd51);

      // reset map: invalid points ignore lane hit, floor at zero, edges of the grid
      send_point(24'h7FFFFF, 24'h800000, 1'b0, 1'b1);
      send_point(24'h800000, 24'h7FFFFF, 1'b0, 1'b0);
      send_point('0, '0, 1'b1, 1'b1);
      send_point('0, '0, 1'b1, 1'b0);
      send_point('0, '0, 1'b1, 1'b0);
      send_point('0, '0, 1'b1, 1'b0);
      send_point(24'hFFFFFF, '0, 1'b1, 1'b1);          // just below origin in x
      send_point('0, 24'hFFFFFF, 1'b1, 1'b1);          // just below origin in y
      send_point(24'h800000, 24'h800000, 1'b1, 1'b1);
      send_point(24'h7FFFFF, '0, 1'b1, 1'b1);          // far past the last column
      send_point('0, 24'h7FFFFF, 1'b1, 1'b0);          // far past the last row
      send_point(24'd12797, 24'd12797, 1'b1, 1'b1);    // last cell of the grid
      send_point(24'd12798, '0, 1'b1, 1'b1);           // one column too far
      send_point(24'd50, '0, 1'b1, 1'b1);              // first point of cell one
      settle();

      // full-scale steps saturate in one hit and clear in one miss
      apply_setting(make_setting('0, '0, 16'hFFFF, 9'd4, 9'd4,
                                 ogcu_pkg::CONF_FULL, ogcu_pkg::CONF_FULL));
      send_point('0, '0, 1'b1, 1'b1);
      send_point('0, '0, 1'b1, 1'b1);
      send_point('0, '0, 1'b1, 1'b0);
      send_point(24'd4, 24'd4, 1'b1, 1'b1);
      send_point(24'd5, '0, 1'b1, 1'b1);
      send_point('0, 24'd5, 1'b1, 1'b1);
      settle();

      // zero scale, lowest origins, oversized grid and steps
      apply_setting(make_setting(24'h800000, 24'h800000, '0, 9'd300, 9'd511, 11'd2047, 11'd1500));
      send_point(24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1);
      send_point(24'h800000, 24'h800000, 1'b1, 1'b0);
      send_point('0, '0, 1'b1, 1'b1);
      settle();

      // zero width, then zero height: nothing is on the grid
      apply_setting(make_setting('0, 24'h7FFFFF, 16'd1311, '0, 9'd5, 11'd1, 11'd1));
      send_point('0, 24'h7FFFFF, 1'b1, 1'b1);
      settle();
      apply_setting(make_setting('0, '0, 16'd1311, 9'd5, '0, 11'd1, 11'd1));
      send_point('0, '0, 1'b1, 1'b1);
      settle();

      // random maps, each followed by a stream of points against it
      for (int phase = 0; phase < PHASES; phase++) begin
         apply_setting(random_setting());
         hit_pct = $urandom_range(15, 85);
         for (int i = 0; i < POINTS_EACH; i++) begin
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            random_point(current_map);
         end
         settle();
      end

      $display("covered %0d points over %0d map settings: %0d updated, %0d invalid, %0d off grid",
               board.checked, settings_applied, board.updated, board.skipped, board.off_grid);
      $display("%0d updates ended at full confidence", board.at_full);
      if (board.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
